### rtl/core/mi3_pkg.sv
// Shared types, constants and fixed-point helpers for the 3x3 matrix inverter.
package mi3_pkg;

  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int ACC_W   = PROD_W + 4;
  localparam int NUM_W   = 2 * FRAC_W + 2;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t m00; word_t m01; word_t m02;
    word_t m10; word_t m11; word_t m12;
    word_t m20; word_t m21; word_t m22;
  } in_item_t;

  typedef struct packed {
    word_t inv00; word_t inv01; word_t inv02;
    word_t inv10; word_t inv11; word_t inv12;
    word_t inv20; word_t inv21; word_t inv22;
    logic  singular;
  } out_item_t;

  // one classified matrix handed from the front part to the back part
  typedef struct packed {
    logic [8:0][DATA_W-1:0] adj;
    word_t                  det;
    logic                   singular;
  } mat_entry_t;

  // cofactor operand indexes: adj[k] = m[CX]*m[CY] - m[CU]*m[CV]
  localparam int CX [9] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int CY [9] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int CU [9] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int CV [9] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // round half up by FRAC_W bits, then saturate to DATA_W signed bits
  function automatic word_t rnd_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0]     t;
    logic signed [ACC_W-1:0]     s;
    logic [ACC_W-DATA_W:0]       hi;
    t  = v + (ACC_W'(1) <<< (FRAC_W - 1));
    s  = t >>> FRAC_W;
    hi = s[ACC_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) return s[DATA_W-1:0];
    return s[ACC_W-1] ? WORD_MIN : WORD_MAX;
  endfunction

endpackage

### rtl/core/mi3_front.sv
// Front part: adjugate and determinant pipeline, classifies singular matrices.
module mi3_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  mi3_pkg::in_item_t    in_item,
  input  logic                 q_full,
  output logic                 q_push,
  output mi3_pkg::mat_entry_t  q_data
);

  logic [2:0] v_r;
  logic       adv;

  mi3_pkg::word_t mm [9];

  logic signed [mi3_pkg::PROD_W-1:0] pp_r [9];
  logic signed [mi3_pkg::PROD_W-1:0] pn_r [9];
  logic signed [mi3_pkg::PROD_W-1:0] pp_nxt [9];
  logic signed [mi3_pkg::PROD_W-1:0] pn_nxt [9];
  mi3_pkg::word_t                    row1_r [3];
  mi3_pkg::word_t                    row2_r [3];
  mi3_pkg::word_t                    adj2_r [9];
  mi3_pkg::word_t                    adj_nxt [9];
  mi3_pkg::word_t                    adj3_r [9];
  logic signed [mi3_pkg::PROD_W-1:0] dp_r [3];
  logic signed [mi3_pkg::PROD_W-1:0] dp_nxt [3];
  logic signed [mi3_pkg::ACC_W-1:0]  dsum;
  mi3_pkg::word_t                    det;

  // whole front moves as one; it holds only when its last stage cannot leave
  assign adv     = !v_r[2] || !q_full;
  assign in_full = !adv;
  assign q_push  = v_r[2] && adv;

  assign mm[0] = in_item.m00; assign mm[1] = in_item.m01; assign mm[2] = in_item.m02;
  assign mm[3] = in_item.m10; assign mm[4] = in_item.m11; assign mm[5] = in_item.m12;
  assign mm[6] = in_item.m20; assign mm[7] = in_item.m21; assign mm[8] = in_item.m22;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      pp_nxt[k]  = mi3_pkg::PROD_W'(mm[mi3_pkg::CX[k]]) * mi3_pkg::PROD_W'(mm[mi3_pkg::CY[k]]);
      pn_nxt[k]  = mi3_pkg::PROD_W'(mm[mi3_pkg::CU[k]]) * mi3_pkg::PROD_W'(mm[mi3_pkg::CV[k]]);
      adj_nxt[k] = mi3_pkg::rnd_sat(mi3_pkg::ACC_W'(pp_r[k]) - mi3_pkg::ACC_W'(pn_r[k]));
    end
    for (int i = 0; i < 3; i++) begin
      dp_nxt[i] = mi3_pkg::PROD_W'(row2_r[i]) * mi3_pkg::PROD_W'(adj2_r[3*i]);
    end
    dsum = mi3_pkg::ACC_W'(dp_r[0]) + mi3_pkg::ACC_W'(dp_r[1]) + mi3_pkg::ACC_W'(dp_r[2]);
    det  = mi3_pkg::rnd_sat(dsum);
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      q_data.adj[k] = adj3_r[k];
    end
    q_data.det      = det;
    q_data.singular = (det == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[1:0], in_push};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) begin
        pp_r[k]   <= pp_nxt[k];
        pn_r[k]   <= pn_nxt[k];
        adj2_r[k] <= adj_nxt[k];
        adj3_r[k] <= adj2_r[k];
      end
      for (int i = 0; i < 3; i++) begin
        row1_r[i] <= mm[i];
        row2_r[i] <= row1_r[i];
        dp_r[i]   <= dp_nxt[i];
      end
    end
  end

endmodule

### rtl/core/mi3_queue.sv
// Short queue of classified matrices between the front and back parts.
module mi3_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mi3_pkg::mat_entry_t  wdata,
  output logic                 full,
  input  logic                 pop,
  output mi3_pkg::mat_entry_t  rdata,
  output logic                 empty
);

  mi3_pkg::mat_entry_t           mem_r [mi3_pkg::QDEPTH];
  logic [mi3_pkg::QPTR_W-1:0]    wptr_r;
  logic [mi3_pkg::QPTR_W-1:0]    rptr_r;
  logic [mi3_pkg::QCNT_W-1:0]    cnt_r;
  logic [mi3_pkg::QCNT_W-1:0]    cnt_nxt;

  assign full  = (cnt_r == mi3_pkg::QCNT_W'(mi3_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mi3_pkg::QCNT_W'(mi3_pkg::QDEPTH))
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("item pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("item popped from empty queue");

endmodule

### rtl/core/mi3_back.sv
// Back part: pipelined reciprocal of the determinant and scaling of the adjugate.
module mi3_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  mi3_pkg::mat_entry_t  q_data,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output mi3_pkg::out_item_t   out_item
);

  localparam int NS = mi3_pkg::NUM_W;

  logic adv;

  // divider stages: index j holds the item after j quotient bits
  logic                       dv_v_r    [NS+1];
  logic [mi3_pkg::DATA_W-1:0] dv_rem_r  [NS+1];
  logic [NS-1:0]              dv_num_r  [NS+1];
  logic [NS-1:0]              dv_q_r    [NS+1];
  logic [mi3_pkg::DATA_W-1:0] dv_mag_r  [NS+1];
  logic                       dv_neg_r  [NS+1];
  logic                       dv_sing_r [NS+1];
  logic [8:0][mi3_pkg::DATA_W-1:0] dv_adj_r [NS+1];

  logic [mi3_pkg::DATA_W-1:0] dv_rem_nxt [NS+1];
  logic [NS-1:0]              dv_q_nxt   [NS+1];
  logic [mi3_pkg::DATA_W:0]   trial      [NS+1];
  logic [mi3_pkg::DATA_W:0]   diff       [NS+1];

  logic [mi3_pkg::DATA_W-1:0] mag0;
  logic [NS-1:0]              num0;

  logic                            rc_v_r;
  mi3_pkg::word_t                  rc_r;
  mi3_pkg::word_t                  rc_nxt;
  logic                            rc_sing_r;
  logic [8:0][mi3_pkg::DATA_W-1:0] rc_adj_r;
  logic [NS-1:0]                   qf;

  logic                              mu_v_r;
  logic                              mu_sing_r;
  logic signed [mi3_pkg::PROD_W-1:0] mu_r   [9];
  logic signed [mi3_pkg::PROD_W-1:0] mu_nxt [9];

  logic                out_v_r;
  mi3_pkg::out_item_t  out_r;
  mi3_pkg::out_item_t  out_nxt;
  mi3_pkg::word_t      ent [9];

  assign adv       = !out_v_r || out_pop;
  assign q_pop     = adv && !q_empty;
  assign out_empty = !out_v_r;
  assign out_item  = out_r;

  // |det| and the rounded numerator 2^(2F) + |det|/2
  assign mag0 = q_data.det[mi3_pkg::DATA_W-1] ? mi3_pkg::DATA_W'(-q_data.det)
                                              : q_data.det;
  assign num0 = (NS'(1) << (2 * mi3_pkg::FRAC_W)) + NS'(mag0 >> 1);

  always_comb begin
    dv_rem_nxt[0] = '0;
    dv_q_nxt[0]   = '0;
    trial[0]      = '0;
    diff[0]       = '0;
    for (int j = 0; j < NS; j++) begin
      trial[j+1] = {dv_rem_r[j], dv_num_r[j][NS-1-j]};
      diff[j+1]  = trial[j+1] - {1'b0, dv_mag_r[j]};
      if (trial[j+1] >= {1'b0, dv_mag_r[j]}) begin
        dv_rem_nxt[j+1] = diff[j+1][mi3_pkg::DATA_W-1:0];
        dv_q_nxt[j+1]   = {dv_q_r[j][NS-2:0], 1'b1};
      end else begin
        dv_rem_nxt[j+1] = trial[j+1][mi3_pkg::DATA_W-1:0];
        dv_q_nxt[j+1]   = {dv_q_r[j][NS-2:0], 1'b0};
      end
    end
  end

  // saturate the quotient and apply the sign of det; zero for a singular matrix
  assign qf = dv_q_r[NS];
  always_comb begin
    if (dv_sing_r[NS]) begin
      rc_nxt = '0;
    end else if (!dv_neg_r[NS]) begin
      rc_nxt = (qf > NS'(mi3_pkg::WORD_MAX)) ? mi3_pkg::WORD_MAX
                                             : qf[mi3_pkg::DATA_W-1:0];
    end else begin
      rc_nxt = (qf > (NS'(mi3_pkg::WORD_MAX) + NS'(1))) ? mi3_pkg::WORD_MIN
                                                        : mi3_pkg::DATA_W'(-qf);
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      mu_nxt[k] = mi3_pkg::PROD_W'(rc_r) * mi3_pkg::PROD_W'($signed(rc_adj_r[k]));
      ent[k]    = mi3_pkg::rnd_sat(mi3_pkg::ACC_W'(mu_r[k]));
    end
    out_nxt.inv00    = ent[0]; out_nxt.inv01 = ent[1]; out_nxt.inv02 = ent[2];
    out_nxt.inv10    = ent[3]; out_nxt.inv11 = ent[4]; out_nxt.inv12 = ent[5];
    out_nxt.inv20    = ent[6]; out_nxt.inv21 = ent[7]; out_nxt.inv22 = ent[8];
    out_nxt.singular = mu_sing_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= NS; j++) dv_v_r[j] <= 1'b0;
      rc_v_r  <= 1'b0;
      mu_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= !q_empty;
      for (int j = 0; j < NS; j++) dv_v_r[j+1] <= dv_v_r[j];
      rc_v_r  <= dv_v_r[NS];
      mu_v_r  <= rc_v_r;
      out_v_r <= mu_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0]  <= '0;
      dv_num_r[0]  <= num0;
      dv_q_r[0]    <= '0;
      dv_mag_r[0]  <= mag0;
      dv_neg_r[0]  <= q_data.det[mi3_pkg::DATA_W-1];
      dv_sing_r[0] <= q_data.singular;
      dv_adj_r[0]  <= q_data.adj;
      for (int j = 0; j < NS; j++) begin
        dv_rem_r[j+1]  <= dv_rem_nxt[j+1];
        dv_num_r[j+1]  <= dv_num_r[j];
        dv_q_r[j+1]    <= dv_q_nxt[j+1];
        dv_mag_r[j+1]  <= dv_mag_r[j];
        dv_neg_r[j+1]  <= dv_neg_r[j];
        dv_sing_r[j+1] <= dv_sing_r[j];
        dv_adj_r[j+1]  <= dv_adj_r[j];
      end
      rc_r      <= rc_nxt;
      rc_sing_r <= dv_sing_r[NS];
      rc_adj_r  <= dv_adj_r[NS];
      for (int k = 0; k < 9; k++) mu_r[k] <= mu_nxt[k];
      mu_sing_r <= rc_sing_r;
      out_r     <= out_nxt;
    end
  end

endmodule

### rtl/core/matrix_inverse_3x3.sv
// Top level of the 3x3 fixed-point matrix inverter.
// Usage:
//   Input channel: drive in_item (nine signed Q16.16 entries, row-major) with
//   in_push; the item is taken at a clock edge where in_push is high and
//   in_full is low. Result channel: while out_empty is low, out_item holds
//   the oldest inverse (nine saturated Q16.16 entries plus the singular flag);
//   assert out_pop to take it. A singular matrix gives all-zero entries.
//   Throughput: one item per cycle, sustained, as long as results are taken.
//   Path from the accepting edge to the result on out_item: the 3-stage
//   adjugate/determinant front, the queue between the parts, and the back
//   (34 stages of a one-bit-per-stage reciprocal divider, then saturation,
//   scaling multiply and rounding).
//   When the receiver stalls, the back pipeline holds, the queue of four
//   items fills, then the front holds and in_full rises.
//   Reset (rst_n low at a clock edge) drops every item in flight; there is
//   no other state.
module matrix_inverse_3x3 (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  mi3_pkg::in_item_t   in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output mi3_pkg::out_item_t  out_item
);

  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_empty;
  mi3_pkg::mat_entry_t  q_wdata;
  mi3_pkg::mat_entry_t  q_rdata;

  mi3_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  mi3_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  mi3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

### tb/tb.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int F = mi3_pkg::FRAC_W;
  localparam int STALL_LIMIT = 5000;

  typedef logic signed [191:0] big_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  mi3_pkg::in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  mi3_pkg::out_item_t out_item;

  mi3_pkg::out_item_t inverse_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit pop_enable = 1'b0;
  bit no_gaps = 1'b0;

  always #5 clk = ~clk;

  matrix_inverse_3x3 uut (.*);

  // round half up by F bits, saturate to DATA_W signed bits
  function automatic mi3_pkg::word_t round_sat(big_t v);
    big_t s;
    s = (v + (big_t'(1) <<< (F - 1))) >>> F;
    if (s > big_t'(mi3_pkg::WORD_MAX)) return mi3_pkg::WORD_MAX;
    if (s < big_t'(mi3_pkg::WORD_MIN)) return mi3_pkg::WORD_MIN;
    return mi3_pkg::word_t'(s);
  endfunction

  function automatic mi3_pkg::word_t cofactor(mi3_pkg::word_t x, mi3_pkg::word_t y,
                                              mi3_pkg::word_t u, mi3_pkg::word_t v);
    return round_sat(big_t'(x) * big_t'(y) - big_t'(u) * big_t'(v));
  endfunction

  function automatic mi3_pkg::out_item_t invert(mi3_pkg::in_item_t mi);
    mi3_pkg::word_t m [9];
    mi3_pkg::word_t a [9];
    mi3_pkg::word_t det, recip;
    big_t mag, q;
    mi3_pkg::out_item_t r;
    m = '{mi.m00, mi.m01, mi.m02, mi.m10, mi.m11, mi.m12, mi.m20, mi.m21, mi.m22};
    a[0] = cofactor(m[4], m[8], m[7], m[5]);
    a[3] = cofactor(m[6], m[5], m[3], m[8]);
    a[6] = cofactor(m[3], m[7], m[6], m[4]);
    a[1] = cofactor(m[7], m[2], m[1], m[8]);
    a[4] = cofactor(m[0], m[8], m[6], m[2]);
    a[7] = cofactor(m[6], m[1], m[0], m[7]);
    a[2] = cofactor(m[1], m[5], m[4], m[2]);
    a[5] = cofactor(m[3], m[2], m[0], m[5]);
    a[8] = cofactor(m[0], m[4], m[3], m[1]);
    det = round_sat(big_t'(m[0]) * big_t'(a[0]) + big_t'(m[1]) * big_t'(a[3])
                    + big_t'(m[2]) * big_t'(a[6]));
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    mag = (det < 0) ? -big_t'(det) : big_t'(det);
    q = ((big_t'(1) <<< (2 * F)) + (mag >>> 1)) / mag;
    if (det >= 0) recip = (q > big_t'(mi3_pkg::WORD_MAX)) ? mi3_pkg::WORD_MAX
                                                         : mi3_pkg::word_t'(q);
    else recip = (q > -big_t'(mi3_pkg::WORD_MIN)) ? mi3_pkg::WORD_MIN
                                                  : mi3_pkg::word_t'(-q);
    r.inv00 = round_sat(big_t'(a[0]) * big_t'(recip));
    r.inv01 = round_sat(big_t'(a[1]) * big_t'(recip));
    r.inv02 = round_sat(big_t'(a[2]) * big_t'(recip));
    r.inv10 = round_sat(big_t'(a[3]) * big_t'(recip));
    r.inv11 = round_sat(big_t'(a[4]) * big_t'(recip));
    r.inv12 = round_sat(big_t'(a[5]) * big_t'(recip));
    r.inv20 = round_sat(big_t'(a[6]) * big_t'(recip));
    r.inv21 = round_sat(big_t'(a[7]) * big_t'(recip));
    r.inv22 = round_sat(big_t'(a[8]) * big_t'(recip));
    r.singular = 1'b0;
    return r;
  endfunction

  // push stays high between back-to-back items; it drops only for a gap
  task automatic send_matrix(mi3_pkg::in_item_t mi);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= mi;
    @(posedge clk);
    while (in_full) @(posedge clk);
    inverse_q.insert(inverse_q.size(), invert(mi));
    @(negedge clk);
  endtask

  // result side: random pop stalls, compares against the oldest prediction
  initial begin
    int wait_n;
    mi3_pkg::out_item_t want;
    forever begin
      @(negedge clk);
      wait_n = no_gaps ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n > 0) begin
        out_pop <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      if (!pop_enable) begin
        out_pop <= 1'b0;
        while (!pop_enable) @(negedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (!(out_pop && !out_empty)) @(posedge clk);
      if (inverse_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_item);
      end else begin
        want = inverse_q.pop_front();
        if (out_item !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %h actual %h", want, out_item);
        end
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic mi3_pkg::word_t rand_word();
    case ($urandom_range(0, 5))
      0: return mi3_pkg::word_t'($urandom);
      1: return mi3_pkg::WORD_MAX;
      2: return mi3_pkg::WORD_MIN;
      3: return mi3_pkg::word_t'($signed($urandom_range(0, 65535)) - 32768);
      default: return mi3_pkg::word_t'(int'($urandom_range(0, 8 << F)) - (4 << F));
    endcase
  endfunction

  function automatic mi3_pkg::in_item_t diag(mi3_pkg::word_t a, mi3_pkg::word_t b,
                                             mi3_pkg::word_t c);
    mi3_pkg::in_item_t mi;
    mi = '0;
    mi.m00 = a; mi.m11 = b; mi.m22 = c;
    return mi;
  endfunction

  task automatic test_directed();
    mi3_pkg::in_item_t mi;
    send_matrix(diag(1 << F, 1 << F, 1 << F));
    send_matrix(diag(2 << F, -(4 << F), 1 << (F - 1)));
    send_matrix('0);                                    // singular, all zero
    send_matrix(diag(mi3_pkg::WORD_MAX, mi3_pkg::WORD_MAX, mi3_pkg::WORD_MAX));
    send_matrix(diag(mi3_pkg::WORD_MIN, mi3_pkg::WORD_MIN, mi3_pkg::WORD_MIN));
    send_matrix(diag(1, 1, 1));                         // determinant rounds to zero
    send_matrix(diag(256, 256, 256));                   // determinant also rounds to zero
    send_matrix(diag(-256, 256, 256));
    mi = '{default: 1 << F};                            // rank one
    send_matrix(mi);
    mi = '{default: mi3_pkg::WORD_MAX};
    send_matrix(mi);
    mi = '{default: mi3_pkg::WORD_MIN};
    send_matrix(mi);
    mi = '{default: -1};
    send_matrix(mi);
    mi = '{2 << F, 1 << F, 0, 1 << F, 3 << F, 1 << F, 0, 1 << F, 4 << F};
    send_matrix(mi);
    mi = '{0, 1 << F, 0, 0, 0, 1 << F, 1 << F, 0, 0};  // permutation
    send_matrix(mi);
    mi = '{mi3_pkg::WORD_MAX, mi3_pkg::WORD_MIN, mi3_pkg::WORD_MAX,
           mi3_pkg::WORD_MIN, mi3_pkg::WORD_MAX, mi3_pkg::WORD_MIN,
           mi3_pkg::WORD_MAX, mi3_pkg::WORD_MIN, 1};
    send_matrix(mi);
  endtask

  task automatic test_random(int n);
    mi3_pkg::in_item_t mi;
    repeat (n) begin
      if ($urandom_range(0, 2) == 0)
        mi = diag(rand_word(), rand_word(), rand_word());
      else
        mi = '{rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
               rand_word(), rand_word(), rand_word(), rand_word()};
      if ($urandom_range(0, 9) == 0) mi.m20 = mi.m00;
      send_matrix(mi);
    end
  endtask

  // back-to-back items with an always-ready receiver, then a held receiver
  // long enough for the whole block to fill and push back
  task automatic test_streaming();
    no_gaps = 1'b1;
    test_random(150);
    pop_enable = 1'b0;
    fork
      test_random(60);
      begin
        repeat (100) @(negedge clk);
        pop_enable = 1'b1;
      end
    join
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    pop_enable = 1'b1;
    test_directed();
    test_random(1800);
    test_streaming();
    in_push <= 1'b0;
    while (inverse_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
